// ===== design/transactional_removal_set_assert.svh =====
// Assertion macros for the transactional removal set.
// Used by the top level; needs nothing else.
`ifndef TRANSACTIONAL_REMOVAL_SET_ASSERT_SVH
`define TRANSACTIONAL_REMOVAL_SET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/trs_pkg.sv =====
// Shared types and constants of the transactional removal set.
// Depends on nothing; the controller, the datapath and the top level take names from it.
package trs_pkg;

	localparam int OP_W     = 3;
	localparam int ELEM_W   = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 11;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_BEGIN  = 3'd2;
	localparam logic [OP_W-1:0] OP_END    = 3'd3;
	localparam logic [OP_W-1:0] OP_UNDO   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOG_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NEST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_TRANS  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ELEM_W-1:0] element;
	} req_item_t;

	typedef struct packed {
		logic                present;
		logic                already_removed;
		logic [STATUS_W-1:0] status;
	} rsp_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
		logic walk_rd;
		logic walk_cnt;
		logic walk_wr;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic undo_go;
		logic walk_more;
	} sts_t;

endpackage

// ===== design/trs_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
// Used with the item types of trs_pkg.
interface trs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/trs_ctrl.sv =====
// Controller state machine of the transactional removal set.
// Depends on trs_pkg for the command and status structs.
module trs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output trs_pkg::cmd_t cmd,
	input  trs_pkg::sts_t sts
);

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_EXEC     = 3'd2;
	localparam logic [2:0] S_WALK_RD  = 3'd3;
	localparam logic [2:0] S_WALK_CNT = 3'd4;
	localparam logic [2:0] S_WALK_WR  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       load;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = !out_valid_q || rsp_ready;
				if (req_valid && req_ready) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.undo_go ? S_WALK_RD : S_IDLE;
			end
			S_WALK_RD: begin
				if (sts.walk_more) begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WALK_CNT;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_WALK_CNT: begin
				cmd.walk_cnt = 1'b1;
				state_d      = S_WALK_WR;
			end
			S_WALK_WR: begin
				cmd.walk_wr = 1'b1;
				state_d     = S_WALK_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign load      = (cmd.exec && !sts.undo_go) || cmd.finish;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/trs_datapath.sv =====
// Datapath of the transactional removal set: count, log and start memories,
// the log and nesting pointers and the result register. Depends on trs_pkg.
module trs_datapath #(
	parameter int SET_SIZE    = 256,
	parameter int LOG_DEPTH   = 1024,
	parameter int MAX_NESTING = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  trs_pkg::cmd_t      cmd,
	output trs_pkg::sts_t      sts,
	input  trs_pkg::req_item_t req_item,
	output trs_pkg::rsp_item_t rsp_item
);

	localparam int CIDX_W    = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
	localparam int LOG_IDX_W = $clog2(LOG_DEPTH);
	localparam int LTOP_W    = $clog2(LOG_DEPTH + 1);
	localparam int TS_IDX_W  = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
	localparam int NEST_W    = $clog2(MAX_NESTING + 1);

	logic [trs_pkg::COUNT_W-1:0] cnt_mem [SET_SIZE];
	logic [trs_pkg::ELEM_W-1:0]  log_mem [LOG_DEPTH];
	logic [LTOP_W-1:0]           ts_mem  [MAX_NESTING];

	logic [trs_pkg::OP_W-1:0]    op_q;
	logic [trs_pkg::ELEM_W-1:0]  elem_q;
	logic [trs_pkg::COUNT_W-1:0] cnt_rd_q;
	logic [trs_pkg::ELEM_W-1:0]  log_rd_q;
	logic [LTOP_W-1:0]           ts_rd_q;
	logic [LTOP_W-1:0]           start_q;
	logic [LTOP_W-1:0]           log_top_q;
	logic [NEST_W-1:0]           nest_q;
	logic [CIDX_W-1:0]           clr_q;
	trs_pkg::rsp_item_t          rsp_q;

	logic                        in_range;
	logic                        cnt_zero;
	logic                        nest_zero;
	logic [NEST_W-1:0]           nest_dec;
	logic [LTOP_W-1:0]           log_top_dec;
	logic                        walk_ok;
	logic                        do_inc;
	logic                        do_log;
	logic                        do_begin;
	trs_pkg::rsp_item_t          res;
	logic                        cnt_we;
	logic [CIDX_W-1:0]           cnt_waddr;
	logic [trs_pkg::COUNT_W-1:0] cnt_wdata;
	logic [CIDX_W-1:0]           cnt_raddr;

	assign in_range    = int'(elem_q) < SET_SIZE;
	assign cnt_zero    = cnt_rd_q == '0;
	assign nest_zero   = nest_q == '0;
	assign nest_dec    = nest_q - 1'b1;
	assign log_top_dec = log_top_q - 1'b1;
	assign walk_ok     = (int'(log_rd_q) < SET_SIZE) && !cnt_zero;

	assign sts.clear_last = clr_q == CIDX_W'(SET_SIZE - 1);
	assign sts.undo_go    = (op_q == trs_pkg::OP_UNDO) && !nest_zero;
	assign sts.walk_more  = log_top_q > start_q;

	// Outcome of the operation held in op_q, using the count read at accept.
	always_comb begin
		res      = '0;
		res.status = trs_pkg::ST_OK;
		do_inc   = 1'b0;
		do_log   = 1'b0;
		do_begin = 1'b0;
		unique case (op_q)
			trs_pkg::OP_LOOKUP: begin
				res.present = in_range && cnt_zero;
			end
			trs_pkg::OP_REMOVE: begin
				if (in_range) begin
					res.already_removed = !cnt_zero;
					priority if (cnt_rd_q >= trs_pkg::COUNT_MAX) begin
						res.status = trs_pkg::ST_SATURATED;
					end else if (nest_zero) begin
						do_inc     = 1'b1;
						res.status = trs_pkg::ST_NO_TRANS;
					end else if (log_top_q >= LTOP_W'(LOG_DEPTH)) begin
						res.status = trs_pkg::ST_LOG_FULL;
					end else begin
						do_inc = 1'b1;
						do_log = 1'b1;
					end
				end
			end
			trs_pkg::OP_BEGIN: begin
				if (nest_q >= NEST_W'(MAX_NESTING)) begin
					res.status = trs_pkg::ST_NEST_FULL;
				end else begin
					do_begin = 1'b1;
				end
			end
			trs_pkg::OP_UNDO: begin
				if (nest_zero) begin
					res.status = trs_pkg::ST_NO_TRANS;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = CIDX_W'(elem_q);
		cnt_wdata = cnt_rd_q + 1'b1;
		priority if (cmd.clear) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else if (cmd.exec && do_inc) begin
			cnt_we = 1'b1;
		end else if (cmd.walk_wr && walk_ok) begin
			cnt_we    = 1'b1;
			cnt_waddr = CIDX_W'(log_rd_q);
			cnt_wdata = cnt_rd_q - 1'b1;
		end else begin
			cnt_we = 1'b0;
		end
	end

	assign cnt_raddr = cmd.accept ? CIDX_W'(req_item.element) : CIDX_W'(log_rd_q);

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cmd.accept || cmd.walk_cnt) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
		end
		if (cmd.exec && do_log) begin
			log_mem[log_top_q[LOG_IDX_W-1:0]] <= elem_q;
		end
		if (cmd.walk_rd) begin
			log_rd_q <= log_mem[log_top_dec[LOG_IDX_W-1:0]];
		end
		if (cmd.exec && do_begin) begin
			ts_mem[nest_q[TS_IDX_W-1:0]] <= log_top_q;
		end
		if (cmd.accept) begin
			ts_rd_q <= ts_mem[nest_dec[TS_IDX_W-1:0]];
			op_q    <= req_item.operation;
			elem_q  <= req_item.element;
		end
		if (cmd.exec && sts.undo_go) begin
			start_q <= ts_rd_q;
		end
		if (cmd.exec && !sts.undo_go) begin
			rsp_q <= res;
		end else if (cmd.finish) begin
			rsp_q <= '{present: 1'b0, already_removed: 1'b0, status: trs_pkg::ST_OK};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			log_top_q <= '0;
			nest_q    <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.exec && do_log) begin
				log_top_q <= log_top_q + 1'b1;
			end else if (cmd.walk_rd) begin
				log_top_q <= log_top_dec;
			end
			if (cmd.exec && do_begin) begin
				nest_q <= nest_q + 1'b1;
			end else if (cmd.exec && sts.undo_go) begin
				nest_q <= nest_dec;
			end
		end
	end

	assign rsp_item = rsp_q;

endmodule

// ===== design/transactional_removal_set.sv =====
// Top level of the transactional removal set.
// Depends on trs_pkg, trs_stream_if, trs_ctrl, trs_datapath and the assertion header.
//
// The req channel carries one operation item (operation, element) and the rsp
// channel returns exactly one result item (present, already_removed, status) for
// every request, in order. An item moves on a clock edge at which valid and ready
// are both high.
// Lookup, remove, begin, end, unknown operations and an undo with no open
// transaction pass through an accept state, which reads the count memory, and
// an execute state, which writes the count, log and start memories as needed and
// loads the result register, from which the result is then offered.
// An undo of an open transaction passes through the same states and then walks the
// log back to the transaction's start: each log entry needs a log read, a count
// read and a count write, and a cleared result is loaded when the walk ends.
// arst_n clears the pointers and the controller; the block then sweeps the count
// memory to zero, one entry a cycle, with req.ready low until the sweep ends.
// A waiting result blocks the next request: a request is taken only when the
// result register is empty or is being emptied in the same cycle.
`include "transactional_removal_set_assert.svh"

module transactional_removal_set #(
	parameter int SET_SIZE    = 256,
	parameter int LOG_DEPTH   = 1024,
	parameter int MAX_NESTING = 16
) (
	input logic         clk,
	input logic         arst_n,
	trs_stream_if.sink   req,
	trs_stream_if.source rsp
);

	trs_pkg::cmd_t cmd;
	trs_pkg::sts_t sts;

	// The controller sequences every operation and owns the result handshake.
	trs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds all of the set's state and the result register.
	trs_datapath #(
		.SET_SIZE    (SET_SIZE),
		.LOG_DEPTH   (LOG_DEPTH),
		.MAX_NESTING (MAX_NESTING)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_item (req.payload),
		.rsp_item (rsp.payload)
	);

	// A request is only taken when its result has somewhere to go.
	`TRS_ASSERT_SAME(a_accept_room, clk, arst_n, req.valid && req.ready, !rsp.valid || rsp.ready, "request taken while result register blocked")
	// One item at a time: no request is taken straight after another.
	`TRS_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready, "request taken while previous one still executing")
	// A result is only loaded into an empty result register.
	`TRS_ASSERT_SAME(a_load_empty, clk, arst_n, cmd.exec || cmd.finish, !rsp.valid, "result loaded over a pending result")

endmodule
